/* design/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the morphing waveshaper oscillator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwo_pkg;

	// Register indexes of the configuration port
	localparam logic CFG_MORPH    = 1'b0;
	localparam logic CFG_EXPONENT = 1'b1;

	localparam logic signed [15:0] MORPH_RESET    = 16'sd0;
	localparam logic [15:0]        EXPONENT_RESET = 16'd4096;

	// Pipeline depths of the iterative parts
	localparam int DIV_STAGES = 31;
	localparam int SQ_STAGES  = 24;
	localparam int SIN_TERMS  = 4;
	localparam int EXP_TERMS  = 8;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// sin(pi/2*x) polynomial coefficients, Q30
	localparam logic [30:0] SIN_COEF [5] = '{
		31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
	};

	// 2^f Taylor coefficients, Q30
	localparam logic [30:0] EXP_COEF [8] = '{
		31'd744261118, 31'd257941248, 31'd59597083, 31'd10327387,
		31'd1431680, 31'd165394, 31'd16377, 31'd1419
	};

	// Warp segment of a phase
	typedef enum logic [1:0] {
		SEG_LOW  = 2'd0,
		SEG_MID  = 2'd1,
		SEG_HIGH = 2'd2
	} seg_t;

	// Warp result handed to the waveform stages
	typedef struct packed {
		logic [30:0] quot;
		seg_t        seg;
	} warp_t;

	// Blend magnitude handed to the power stages
	typedef struct packed {
		logic [30:0] mag;
		logic        neg;
	} mag_t;

endpackage

/* design/mwo_warp.sv */
// ----------------------------------------------------------------------------
// mwo_warp
// Piecewise phase warp: segment select and a pipelined restoring divider,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwo_warp import mwo_pkg::*; #(
	parameter int PHASE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic [15:0]           div_a,
	input  logic [15:0]           div_b,
	output logic                  out_valid,
	output warp_t                 out_warp
);

	localparam int U_SHIFT = 32 - PHASE_BITS;

	logic [31:0] u;
	logic [32:0] seg13;
	logic [32:0] bound;
	logic [32:0] num_x;
	logic [47:0] num;
	logic [15:0] div_d;
	seg_t        seg_d;

	logic        v_s    [DIV_STAGES+1];
	logic [15:0] rem_s  [DIV_STAGES+1];
	logic [30:0] low_s  [DIV_STAGES+1];
	logic [15:0] dvs_s  [DIV_STAGES+1];
	seg_t        seg_s  [DIV_STAGES+1];

	// Pick the segment and form the numerator
	always_comb begin
		u     = 32'(phase) << U_SHIFT;
		seg13 = {2'b0, div_a, 15'd0};
		bound = seg13 + {1'b0, div_b, 16'd0};
		if ({1'b0, u} < seg13) begin
			seg_d = SEG_LOW;
			num_x = {1'b0, u};
			div_d = div_a;
		end else if ({1'b0, u} < bound) begin
			seg_d = SEG_MID;
			num_x = {1'b0, u} - seg13;
			div_d = div_b;
		end else begin
			seg_d = SEG_HIGH;
			num_x = 33'h1_0000_0000 - {1'b0, u};
			div_d = div_a;
		end
		num = {num_x[32:0], 15'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num[46:31];
			low_s[0] <= num[30:0];
			dvs_s[0] <= div_d;
			seg_s[0] <= seg_d;
		end
	end

	// Divider stages: shift in one numerator bit, subtract when it fits
	for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
		logic [16:0] rs;
		logic [16:0] diff;
		logic        ge;

		always_comb begin
			rs   = {rem_s[i-1], low_s[i-1][30]};
			diff = rs - {1'b0, dvs_s[i-1]};
			ge   = (rs >= {1'b0, dvs_s[i-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[15:0] : rs[15:0];
				low_s[i] <= {low_s[i-1][29:0], ge};
				dvs_s[i] <= dvs_s[i-1];
				seg_s[i] <= seg_s[i-1];
			end
		end
	end

	assign out_valid     = v_s[DIV_STAGES];
	assign out_warp.quot = low_s[DIV_STAGES];
	assign out_warp.seg  = seg_s[DIV_STAGES];

endmodule

/* design/mwo_wave.sv */
// ----------------------------------------------------------------------------
// mwo_wave
// Sine and triangle on the warped phase, then the morph blend to a
// magnitude and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwo_wave import mwo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  warp_t              in_warp,
	input  logic [15:0]        div_a,
	input  logic signed [15:0] morph_m,
	output logic               out_valid,
	output mag_t               out_mag
);

	// Stage 1: warped phase, quarter fold, triangle
	logic [31:0]        w;
	logic [30:0]        x_d;
	logic signed [31:0] tri_d;
	logic               v_s1, neg_s1;
	logic [30:0]        x_s1;
	logic signed [31:0] tri_s1;

	always_comb begin
		case (in_warp.seg)
			SEG_MID:  w = {1'b0, in_warp.quot} + 32'h4000_0000;
			SEG_HIGH: w = 32'd0 - {1'b0, in_warp.quot};
			default:  w = {1'b0, in_warp.quot};
		endcase
		x_d   = w[30] ? (Q30_ONE - {1'b0, w[29:0]}) : {1'b0, w[29:0]};
		tri_d = (w[31] ^ w[30]) ? $signed(32'h8000_0000 - w) : $signed(w);
	end

	// Stage 2: x squared
	logic [61:0]        xx;
	logic               v_s2, neg_s2;
	logic [30:0]        x_s2, x2_s2;
	logic signed [31:0] tri_s2;

	assign xx = 62'(x_s1) * 62'(x_s1);

	// Polynomial stages
	logic               v_h    [SIN_TERMS+1];
	logic [30:0]        t_h    [SIN_TERMS+1];
	logic [30:0]        x_h    [SIN_TERMS+1];
	logic [30:0]        x2_h   [SIN_TERMS+1];
	logic               neg_h  [SIN_TERMS+1];
	logic signed [31:0] tri_h  [SIN_TERMS+1];

	assign v_h[0]   = v_s2;
	assign t_h[0]   = SIN_COEF[4];
	assign x_h[0]   = x_s2;
	assign x2_h[0]  = x2_s2;
	assign neg_h[0] = neg_s2;
	assign tri_h[0] = tri_s2;

	for (genvar j = 1; j <= SIN_TERMS; j++) begin : g_sin
		logic [61:0] p;
		assign p = 62'(x2_h[j-1]) * 62'(t_h[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_h[j] <= 1'b0;
			end else if (en) begin
				v_h[j] <= v_h[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_h[j]   <= SIN_COEF[SIN_TERMS-j] - p[60:30];
				x_h[j]   <= x_h[j-1];
				x2_h[j]  <= x2_h[j-1];
				neg_h[j] <= neg_h[j-1];
				tri_h[j] <= tri_h[j-1];
			end
		end
	end

	// Final sine product and sign
	logic [61:0]        sp;
	logic               v_s7;
	logic signed [31:0] sine_s7, tri_s7;
	assign sp = 62'(x_h[SIN_TERMS]) * 62'(t_h[SIN_TERMS]);

	// Blend products
	logic               v_s8;
	logic signed [48:0] pa_s8;
	logic signed [47:0] pb_s8;

	// Sum, magnitude
	logic signed [49:0] sum;
	logic [49:0]        sum_abs;
	logic               v_s9;
	mag_t               mag_s9;

	always_comb begin
		sum     = 50'(pa_s8) + 50'(pb_s8);
		sum_abs = sum[49] ? 50'(-sum) : 50'(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s7 <= v_h[SIN_TERMS];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_d;
			neg_s1  <= w[31];
			tri_s1  <= tri_d;
			x_s2    <= x_s1;
			x2_s2   <= xx[60:30];
			neg_s2  <= neg_s1;
			tri_s2  <= tri_s1;
			sine_s7 <= neg_h[SIN_TERMS] ? -$signed({1'b0, sp[60:30]})
			                            : $signed({1'b0, sp[60:30]});
			tri_s7  <= tri_h[SIN_TERMS];
			pa_s8   <= 49'(sine_s7) * 49'($signed({1'b0, div_a}));
			pb_s8   <= 48'(tri_s7) * 48'(morph_m);
			mag_s9.mag <= sum_abs[45:15];
			mag_s9.neg <= sum[49];
		end
	end

	assign out_valid = v_s9;
	assign out_mag   = mag_s9;

endmodule

/* design/mwo_pow.sv */
// ----------------------------------------------------------------------------
// mwo_pow
// Sign-preserving power curve: log2 by repeated squaring, scale by the
// exponent, exp2 by polynomial, then shift, saturate and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwo_pow import mwo_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  mag_t                   in_mag,
	input  logic [15:0]            exponent,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] sample
);

	// Stage 1: leading one position
	logic [4:0]  k_d;
	logic        v_s1, zero_s1, neg_s1;
	logic [30:0] mag_s1;
	logic [4:0]  k_s1;

	always_comb begin
		k_d = 5'd0;
		for (int i = 0; i < 31; i++) begin
			if (in_mag.mag[i]) begin
				k_d = 5'(i);
			end
		end
	end

	// Stage 2: normalize to [1,2) in Q30
	logic        v_s2, zero_s2, neg_s2;
	logic [30:0] norm_s2;
	logic [4:0]  k_s2;

	// Squaring stages, one fraction bit each
	logic        v_q    [SQ_STAGES+1];
	logic [30:0] norm_q [SQ_STAGES+1];
	logic [23:0] frac_q [SQ_STAGES+1];
	logic [4:0]  k_sq   [SQ_STAGES+1];
	logic        zero_sq[SQ_STAGES+1];
	logic        neg_sq [SQ_STAGES+1];

	assign v_q[0]     = v_s2;
	assign norm_q[0]  = norm_s2;
	assign frac_q[0]  = 24'd0;
	assign k_sq[0]    = k_s2;
	assign zero_sq[0] = zero_s2;
	assign neg_sq[0]  = neg_s2;

	for (genvar i = 1; i <= SQ_STAGES; i++) begin : g_sq
		logic [61:0] sq;
		assign sq = 62'(norm_q[i-1]) * 62'(norm_q[i-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= v_q[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				norm_q[i]  <= sq[61] ? sq[61:31] : sq[60:30];
				frac_q[i]  <= {frac_q[i-1][22:0], sq[61]};
				k_sq[i]    <= k_sq[i-1];
				zero_sq[i] <= zero_sq[i-1];
				neg_sq[i]  <= neg_sq[i-1];
			end
		end
	end

	// Negated log, unity flag
	logic        v_s3, one_s3, zero_s3, neg_s3;
	logic [28:0] lm_s3;

	// Scale by exponent
	logic [44:0] pprod;
	logic        v_s4, one_s4, zero_s4, neg_s4;
	logic [32:0] pm_s4;
	assign pprod = 45'(lm_s3) * 45'(exponent);

	// Split into shift and fraction
	logic [23:0] rdiff;
	logic        v_s5, one_s5, zero_s5, neg_s5, kill_s5;
	logic [9:0]  shift_d, shift_s5;
	logic [29:0] f_s5;

	always_comb begin
		rdiff   = 24'(25'h100_0000 - {1'b0, pm_s4[23:0]});
		shift_d = (pm_s4[23:0] == 24'd0) ? {1'b0, pm_s4[32:24]}
		                                 : {1'b0, pm_s4[32:24]} + 10'd1;
	end

	// Exp polynomial stages, last one adds 1.0
	logic        v_e    [EXP_TERMS+1];
	logic [30:0] t_e    [EXP_TERMS+1];
	logic [29:0] f_e    [EXP_TERMS+1];
	logic [9:0]  sh_e   [EXP_TERMS+1];
	logic        one_e  [EXP_TERMS+1];
	logic        kill_e [EXP_TERMS+1];
	logic        zero_e [EXP_TERMS+1];
	logic        neg_e  [EXP_TERMS+1];

	assign v_e[0]    = v_s5;
	assign t_e[0]    = EXP_COEF[EXP_TERMS-1];
	assign f_e[0]    = f_s5;
	assign sh_e[0]   = shift_s5;
	assign one_e[0]  = one_s5;
	assign kill_e[0] = kill_s5;
	assign zero_e[0] = zero_s5;
	assign neg_e[0]  = neg_s5;

	for (genvar j = 1; j <= EXP_TERMS; j++) begin : g_exp
		localparam int          CIDX = (j == EXP_TERMS) ? 0 : EXP_TERMS-1-j;
		localparam logic [30:0] CADD = (j == EXP_TERMS) ? Q30_ONE : EXP_COEF[CIDX];
		logic [60:0] p;
		assign p = 61'(f_e[j-1]) * 61'(t_e[j-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_e[j] <= 1'b0;
			end else if (en) begin
				v_e[j] <= v_e[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_e[j]    <= CADD + p[60:30];
				f_e[j]    <= f_e[j-1];
				sh_e[j]   <= sh_e[j-1];
				one_e[j]  <= one_e[j-1];
				kill_e[j] <= kill_e[j-1];
				zero_e[j] <= zero_e[j-1];
				neg_e[j]  <= neg_e[j-1];
			end
		end
	end

	// Final shift, saturate, sign
	logic [30:0]            yv;
	logic [SAMPLE_BITS-1:0] res, lim, smp_d, smp_s6;
	logic                   v_s6;

	always_comb begin
		if (one_e[EXP_TERMS]) begin
			yv = Q30_ONE;
		end else if (kill_e[EXP_TERMS]) begin
			yv = 31'd0;
		end else begin
			yv = t_e[EXP_TERMS] >> sh_e[EXP_TERMS];
		end
		res = yv[30:31-SAMPLE_BITS];
		lim = neg_e[EXP_TERMS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
		                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		if (res > lim) begin
			res = lim;
		end
		if (zero_e[EXP_TERMS]) begin
			smp_d = '0;
		end else if (neg_e[EXP_TERMS]) begin
			smp_d = SAMPLE_BITS'(0) - res;
		end else begin
			smp_d = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_q[SQ_STAGES];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_e[EXP_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= in_mag.mag;
			k_s1     <= k_d;
			zero_s1  <= (in_mag.mag == 31'd0);
			neg_s1   <= in_mag.neg;
			norm_s2  <= mag_s1 << (5'd30 - k_s1);
			k_s2     <= k_s1;
			zero_s2  <= zero_s1;
			neg_s2   <= neg_s1;
			lm_s3    <= {5'd30 - k_sq[SQ_STAGES], 24'd0} - {5'd0, frac_q[SQ_STAGES]};
			one_s3   <= (k_sq[SQ_STAGES] == 5'd30);
			zero_s3  <= zero_sq[SQ_STAGES];
			neg_s3   <= neg_sq[SQ_STAGES];
			pm_s4    <= pprod[44:12];
			one_s4   <= one_s3;
			zero_s4  <= zero_s3;
			neg_s4   <= neg_s3;
			one_s5   <= one_s4 || (pm_s4 == 33'd0);
			shift_s5 <= shift_d;
			kill_s5  <= (shift_d > 10'd40);
			f_s5     <= (pm_s4[23:0] == 24'd0) ? 30'd0 : {rdiff, 6'd0};
			zero_s5  <= zero_s4;
			neg_s5   <= neg_s4;
			smp_s6   <= smp_d;
		end
	end

	assign out_valid = v_s6;
	assign sample    = smp_s6;

endmodule

/* design/morphing_waveshaper_oscillator.sv */
// ----------------------------------------------------------------------------
// morphing_waveshaper_oscillator
// Phase in, shaped sine/triangle sample out, fully pipelined.
// ----------------------------------------------------------------------------
// One phase is taken per clock and one sample leaves per clock while the sink
// keeps m_tready high. Each item passes the warp divider, the waveform and
// blend stages and the log/exp power curve, which resolve one quotient bit
// and one log bit per stage. An output register with a skid entry keeps the
// pipeline moving while the sink stalls until a finished item meets the held
// output; that item fills the skid entry, and the pipeline holds until it drains.
`timescale 1ns / 1ps

module morphing_waveshaper_oscillator import mwo_pkg::*; #(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((PHASE_BITS+7)/8)*8-1:0]    s_tdata,   // [PHASE_BITS-1:0] phase
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_BITS-1:0] sample
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [15:0]                        cfg_data
);

	localparam int OUT_TW = ((SAMPLE_BITS+7)/8)*8;

	logic signed [15:0]     morph_q;
	logic [15:0]            exponent_q;
	logic signed [15:0]     morph_m;
	logic [15:0]            div_a, div_b;
	logic                   en;
	logic                   warp_valid, wave_valid, tail_valid;
	warp_t                  warp;
	mag_t                   mag;
	logic [SAMPLE_BITS-1:0] tail_sample;
	logic                   out_valid_q, skid_valid_q;
	logic [SAMPLE_BITS-1:0] out_q, skid_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			morph_q    <= MORPH_RESET;
			exponent_q <= EXPONENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MORPH:    morph_q    <= $signed(cfg_data);
				CFG_EXPONENT: exponent_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Clamp morph off the negative end, derive segment divisors
	always_comb begin
		morph_m = (morph_q == -16'sd32768) ? -16'sd32767 : morph_q;
		div_a   = 16'(17'sd32768 - 17'(morph_m));
		div_b   = 16'(17'sd32768 + 17'(morph_m));
	end

	// Pipeline advances while the skid entry is free
	assign en       = !skid_valid_q;
	assign s_tready = en;

	mwo_warp #(.PHASE_BITS(PHASE_BITS)) u_warp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.phase     (s_tdata[PHASE_BITS-1:0]),
		.div_a     (div_a),
		.div_b     (div_b),
		.out_valid (warp_valid),
		.out_warp  (warp)
	);

	mwo_wave u_wave (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (warp_valid),
		.in_warp   (warp),
		.div_a     (div_a),
		.morph_m   (morph_m),
		.out_valid (wave_valid),
		.out_mag   (mag)
	);

	mwo_pow #(.SAMPLE_BITS(SAMPLE_BITS)) u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (wave_valid),
		.in_mag    (mag),
		.exponent  (exponent_q),
		.out_valid (tail_valid),
		.sample    (tail_sample)
	);

	// Output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (m_tready) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (tail_valid) begin
				if (!out_valid_q || m_tready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (tail_valid) begin
			if (!out_valid_q || m_tready) begin
				out_q <= tail_sample;
			end else begin
				skid_q <= tail_sample;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TW'(out_q);

	// A filled skid entry always sits behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output valid");

	// The skid entry only fills when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && tail_valid))
		else $error("skid entry filled without a stalled output");

	// A finished item reaching the tail is always captured
	a_tail_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_valid && en) |=> out_valid_q)
		else $error("pipeline result dropped");

endmodule
